FILE: rtl/radio_api_frame_receiver_top_assert.svh
// Assertion macros shared by the radio API frame receiver RTL.
`ifndef RADIO_API_FRAME_RECEIVER_TOP_ASSERT_SVH
`define RADIO_API_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define RAFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rafr assertion failed");

// Next-cycle implication, disabled while reset is low
`define RAFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rafr assertion failed");

`endif

FILE: rtl/rafr_pkg.sv
// Types and constants of the radio API frame receiver.
package rafr_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int ADDR_W  = 64;
    localparam int EVENT_W = 3;
    localparam int KIND_W  = 2;

    localparam logic [BYTE_W-1:0] DELIM       = 8'h7E;
    localparam logic [BYTE_W-1:0] TYPE_RX     = 8'h90;
    localparam logic [BYTE_W-1:0] TYPE_STATUS = 8'h8B;
    localparam logic [BYTE_W-1:0] SUM_GOOD    = 8'hFF;
    localparam logic [BYTE_W-1:0] FRAME_ID_MAX   = 8'd255;
    localparam logic [BYTE_W-1:0] FRAME_ID_FIRST = 8'd1;

    localparam logic [LEN_W-1:0] RX_HEADER_LEN    = 16'd12;
    localparam logic [LEN_W-1:0] STATUS_MIN_LEN   = 16'd6;
    localparam logic [LEN_W-1:0] STATUS_POS       = 16'd5;
    localparam logic [LEN_W-1:0] ADDR_LAST_POS    = 16'd8;
    localparam logic [LEN_W-1:0] MIN_RX_LEN_RESET = 16'd12;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LENHI = 3'd1,
        PH_LENLO = 3'd2,
        PH_BODY  = 3'd3,
        PH_SUM   = 3'd4
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_PAYLOAD   = 3'd0,
        EV_GOOD      = 3'd1,
        EV_SUM_BAD   = 3'd2,
        EV_TOO_SHORT = 3'd3,
        EV_STRAY     = 3'd4
    } t_event;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX         = 2'd0,
        KIND_STATUS_OK  = 2'd1,
        KIND_STATUS_BAD = 2'd2,
        KIND_OTHER      = 2'd3
    } t_kind;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic [KIND_W-1:0]  frame_kind;
        logic [ADDR_W-1:0]  sender_address;
        logic [BYTE_W-1:0]  delivery_status;
        logic [BYTE_W-1:0]  frame_counter;
        logic [LEN_W-1:0]   payload_count;
    } t_result;

endpackage

FILE: rtl/rafr_ifs.sv
// Byte input and result output channel interfaces of the frame receiver.
interface rafr_in_if;
    logic                         valid;
    logic                         ready;
    logic [rafr_pkg::BYTE_W-1:0]  byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface rafr_out_if;
    logic                         valid;
    logic                         ready;
    logic [rafr_pkg::EVENT_W-1:0] event_res;
    logic [rafr_pkg::BYTE_W-1:0]  data_byte;
    logic [rafr_pkg::KIND_W-1:0]  frame_kind;
    logic [rafr_pkg::ADDR_W-1:0]  sender_address;
    logic [rafr_pkg::BYTE_W-1:0]  delivery_status;
    logic [rafr_pkg::BYTE_W-1:0]  frame_counter;
    logic [rafr_pkg::LEN_W-1:0]   payload_count;

    modport source (output valid, output event_res, output data_byte, output frame_kind,
                    output sender_address, output delivery_status, output frame_counter,
                    output payload_count, input ready);
    modport sink   (input valid, input event_res, input data_byte, input frame_kind,
                    input sender_address, input delivery_status, input frame_counter,
                    input payload_count, output ready);
endinterface

FILE: rtl/radio_api_frame_receiver_top.sv
// Radio API frame receiver: byte-wise frame parser with a two-entry result buffer.
//
// Usage:
//   i_byte carries one received link byte per beat (valid/ready). o_res carries
//   one result per beat: a payload byte of a receive frame, an end-of-frame
//   event (good, checksum bad, too short) or a stray byte seen while hunting.
//   A byte causes zero or one result.
//   i_cfg_we/i_cfg_wdata write min_receive_length; write it only while idle.
//   Throughput: one byte per cycle while i_byte.ready is high. Each byte updates the
//   parser state in the cycle it is accepted; its result is registered into r_out,
//   or into the skid register while o_res stalls, and then shown on o_res.
//   Stall: the result register plus a one-entry skid register let the input
//   keep taking beats after o_res stalls until a second result is waiting;
//   i_byte.ready drops while the skid register is full and rises again once
//   o_res drains.
//   Reset (synchronous, active low): parser hunts for the delimiter, frame
//   counter is 1, min_receive_length is 12, both result registers are empty.
`include "radio_api_frame_receiver_top_assert.svh"

module radio_api_frame_receiver_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rafr_in_if.sink                      i_byte,
    rafr_out_if.source                   o_res,
    input  logic                         i_cfg_we,
    input  logic [rafr_pkg::LEN_W-1:0]   i_cfg_wdata
);

    // Parser state
    rafr_pkg::t_phase                  r_phase, n_phase;
    logic [rafr_pkg::LEN_W-1:0]        r_len, n_len;
    logic [rafr_pkg::LEN_W-1:0]        r_pos, n_pos;
    logic [rafr_pkg::BYTE_W-1:0]       r_sum, n_sum;
    logic [rafr_pkg::BYTE_W-1:0]       r_type, n_type;
    logic [rafr_pkg::ADDR_W-1:0]       r_addr, n_addr;
    logic [rafr_pkg::BYTE_W-1:0]       r_stat, n_stat;
    logic [rafr_pkg::BYTE_W-1:0]       r_fid, n_fid;
    logic [rafr_pkg::LEN_W-1:0]        r_min_rx_len;

    // Result buffering
    rafr_pkg::t_result                 r_out, r_skid, res;
    logic                              r_out_v, r_skid_v, res_v;

    logic                              accept, take;
    logic [rafr_pkg::BYTE_W-1:0]       b;
    logic [rafr_pkg::LEN_W-1:0]        pos_inc;
    logic [rafr_pkg::LEN_W-1:0]        len_lo;
    logic [rafr_pkg::LEN_W-1:0]        pay_cnt;
    logic [rafr_pkg::KIND_W-1:0]       kind;
    logic [rafr_pkg::BYTE_W-1:0]       sum_fin;
    logic                              short_frame;

    assign b       = i_byte.byte_in;
    assign accept  = i_byte.valid && i_byte.ready;
    assign take    = o_res.valid && o_res.ready;
    assign pos_inc = r_pos + 16'd1;
    assign len_lo  = {r_len[15:8], b};
    assign sum_fin = r_sum + b;

    // Kind and payload count of the frame held in state
    always_comb begin
        if (r_type == rafr_pkg::TYPE_RX) begin
            kind = rafr_pkg::KIND_RX;
        end else if (r_type == rafr_pkg::TYPE_STATUS) begin
            kind = (r_stat == '0) ? rafr_pkg::KIND_STATUS_OK : rafr_pkg::KIND_STATUS_BAD;
        end else begin
            kind = rafr_pkg::KIND_OTHER;
        end
        if (r_type == rafr_pkg::TYPE_RX && r_len >= rafr_pkg::RX_HEADER_LEN) begin
            pay_cnt = r_len - rafr_pkg::RX_HEADER_LEN;
        end else begin
            pay_cnt = '0;
        end
        short_frame = (r_type == rafr_pkg::TYPE_RX && r_len < r_min_rx_len) ||
                      (r_type == rafr_pkg::TYPE_STATUS && r_len < rafr_pkg::STATUS_MIN_LEN);
    end

    // Next phase
    always_comb begin
        unique case (r_phase)
            rafr_pkg::PH_LENHI: n_phase = rafr_pkg::PH_LENLO;
            rafr_pkg::PH_LENLO: n_phase = (len_lo == '0) ? rafr_pkg::PH_SUM : rafr_pkg::PH_BODY;
            rafr_pkg::PH_BODY:  n_phase = (pos_inc >= r_len) ? rafr_pkg::PH_SUM
                                                             : rafr_pkg::PH_BODY;
            rafr_pkg::PH_SUM:   n_phase = rafr_pkg::PH_HUNT;
            default:            n_phase = (b == rafr_pkg::DELIM) ? rafr_pkg::PH_LENHI
                                                                 : rafr_pkg::PH_HUNT;
        endcase
    end

    // Field updates and result for the byte on the input
    always_comb begin
        n_len  = r_len;
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_type = r_type;
        n_addr = r_addr;
        n_stat = r_stat;
        n_fid  = r_fid;
        res_v  = 1'b0;
        res.event_res       = rafr_pkg::EV_PAYLOAD;
        res.data_byte       = b;
        res.frame_kind      = kind;
        res.sender_address  = r_addr;
        res.delivery_status = r_stat;
        res.frame_counter   = r_fid;
        res.payload_count   = pay_cnt;
        unique case (r_phase)
            rafr_pkg::PH_LENHI: begin
                n_len = {b, 8'h00};
            end
            rafr_pkg::PH_LENLO: begin
                n_len = len_lo;
                n_pos = '0;
                n_sum = '0;
            end
            rafr_pkg::PH_BODY: begin
                n_sum = sum_fin;
                n_pos = pos_inc;
                if (r_pos == '0) begin
                    n_type = b;
                end else if (r_type == rafr_pkg::TYPE_RX) begin
                    if (r_pos <= rafr_pkg::ADDR_LAST_POS) begin
                        n_addr = {r_addr[rafr_pkg::ADDR_W-9:0], b};
                    end else if (r_pos >= rafr_pkg::RX_HEADER_LEN) begin
                        res_v = 1'b1;
                    end
                end else if (r_type == rafr_pkg::TYPE_STATUS && r_pos == rafr_pkg::STATUS_POS) begin
                    n_stat = b;
                end
            end
            rafr_pkg::PH_SUM: begin
                res_v = 1'b1;
                if (short_frame) begin
                    res.event_res = rafr_pkg::EV_TOO_SHORT;
                end else if (sum_fin != rafr_pkg::SUM_GOOD) begin
                    res.event_res = rafr_pkg::EV_SUM_BAD;
                end else begin
                    res.event_res = rafr_pkg::EV_GOOD;
                    if (kind == rafr_pkg::KIND_STATUS_OK) begin
                        n_fid = (r_fid >= rafr_pkg::FRAME_ID_MAX) ? rafr_pkg::FRAME_ID_FIRST
                                                                 : r_fid + 8'd1;
                    end
                end
                res.frame_counter = n_fid;
            end
            default: begin
                if (b == rafr_pkg::DELIM) begin
                    n_type = '0;
                    n_addr = '0;
                    n_stat = '0;
                end else begin
                    res_v = 1'b1;
                    res.event_res       = rafr_pkg::EV_STRAY;
                    res.frame_kind      = rafr_pkg::KIND_OTHER;
                    res.sender_address  = '0;
                    res.delivery_status = '0;
                    res.payload_count   = '0;
                end
            end
        endcase
    end

    // Advance parser state on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rafr_pkg::PH_HUNT;
            r_len   <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_type  <= '0;
            r_addr  <= '0;
            r_stat  <= '0;
            r_fid   <= rafr_pkg::FRAME_ID_FIRST;
        end else if (accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_type  <= n_type;
            r_addr  <= n_addr;
            r_stat  <= n_stat;
            r_fid   <= n_fid;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rx_len <= rafr_pkg::MIN_RX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_min_rx_len <= i_cfg_wdata;
        end
    end

    // Result register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= accept && res_v;
            end
        end else if (accept && res_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // Result payloads
    always_ff @(posedge i_clk) begin
        if (!r_out_v || take) begin
            r_out <= r_skid_v ? r_skid : res;
        end
        if (r_out_v && !take && !r_skid_v) begin
            r_skid <= res;
        end
    end

    // Drive the channels
    assign i_byte.ready          = !r_skid_v;
    assign o_res.valid           = r_out_v;
    assign o_res.event_res       = r_out.event_res;
    assign o_res.data_byte       = r_out.data_byte;
    assign o_res.frame_kind      = r_out.frame_kind;
    assign o_res.sender_address  = r_out.sender_address;
    assign o_res.delivery_status = r_out.delivery_status;
    assign o_res.frame_counter   = r_out.frame_counter;
    assign o_res.payload_count   = r_out.payload_count;

    // Checks
    `RAFR_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `RAFR_ASSERT_NOW(a_fid_nonzero, i_clk, i_rst_n, 1'b1, r_fid != '0)
    `RAFR_ASSERT_NEXT(a_stray_gives_result, i_clk, i_rst_n, accept && r_phase == rafr_pkg::PH_HUNT && b != rafr_pkg::DELIM, r_out_v)
    `RAFR_ASSERT_NEXT(a_fid_moves_at_sum, i_clk, i_rst_n, !(accept && r_phase == rafr_pkg::PH_SUM), $stable(r_fid))

endmodule

FILE: sim/testbench.sv
// Testbench for the radio API frame receiver: byte stimulus, result checking, watchdog.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rafr_pkg::*;

    typedef logic [BYTE_W-1:0] t_octet;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 100;

    // Byte-level frame parser and the results it still owes
    class frame_event_checker;
        t_result     owed_results[$];
        int unsigned failures;
        logic [LEN_W-1:0]  min_rx_len;
        t_phase            parse_phase;
        logic [LEN_W-1:0]  frame_len;
        logic [LEN_W-1:0]  body_pos;
        t_octet            body_sum;
        t_octet            frame_type;
        logic [ADDR_W-1:0] src_addr;
        t_octet            tx_status;
        t_octet            frame_id;

        function new();
            failures    = 0;
            min_rx_len  = MIN_RX_LEN_RESET;
            parse_phase = PH_HUNT;
            frame_len   = '0;
            body_pos    = '0;
            body_sum    = '0;
            frame_type  = '0;
            src_addr    = '0;
            tx_status   = '0;
            frame_id    = FRAME_ID_FIRST;
        endfunction

        function void set_min_rx_len(logic [LEN_W-1:0] value);
            min_rx_len = value;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function t_kind kind_now();
            if (frame_type == TYPE_RX) return KIND_RX;
            if (frame_type == TYPE_STATUS)
                return (tx_status == '0) ? KIND_STATUS_OK : KIND_STATUS_BAD;
            return KIND_OTHER;
        endfunction

        function t_result make_result(t_event ev, t_octet data, t_kind kind);
            t_result r;
            r.event_res       = ev;
            r.data_byte       = data;
            r.frame_kind      = kind;
            r.sender_address  = src_addr;
            r.delivery_status = tx_status;
            r.frame_counter   = frame_id;
            r.payload_count   = (kind == KIND_RX && frame_len >= RX_HEADER_LEN) ?
                                frame_len - RX_HEADER_LEN : '0;
            return r;
        endfunction

        // Advance the parser by one accepted byte and queue what it should produce
        function void take_byte(t_octet b);
            t_result r;
            t_kind   kind;
            t_octet  total;
            logic    short_frame;
            case (parse_phase)
                PH_LENHI: begin
                    frame_len   = {b, 8'h00};
                    parse_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    frame_len   = frame_len | LEN_W'(b);
                    body_pos    = '0;
                    body_sum    = '0;
                    parse_phase = (frame_len == '0) ? PH_SUM : PH_BODY;
                end
                PH_BODY: begin
                    body_sum = body_sum + b;
                    if (body_pos == '0) begin
                        frame_type = b;
                    end else if (frame_type == TYPE_RX) begin
                        if (body_pos <= ADDR_LAST_POS)
                            src_addr = {src_addr[ADDR_W-BYTE_W-1:0], b};
                        else if (body_pos >= RX_HEADER_LEN)
                            owed_results.push_back(make_result(EV_PAYLOAD, b, KIND_RX));
                    end else if (frame_type == TYPE_STATUS && body_pos == STATUS_POS) begin
                        tx_status = b;
                    end
                    body_pos = body_pos + 16'd1;
                    if (body_pos >= frame_len) parse_phase = PH_SUM;
                end
                PH_SUM: begin
                    kind  = kind_now();
                    total = body_sum + b;
                    short_frame = (frame_type == TYPE_RX && frame_len < min_rx_len) ||
                                  (frame_type == TYPE_STATUS && frame_len < STATUS_MIN_LEN);
                    if (short_frame) begin
                        r = make_result(EV_TOO_SHORT, b, kind);
                    end else if (total != SUM_GOOD) begin
                        r = make_result(EV_SUM_BAD, b, kind);
                    end else begin
                        if (kind == KIND_STATUS_OK)
                            frame_id = (frame_id >= FRAME_ID_MAX) ? FRAME_ID_FIRST
                                                                  : frame_id + 8'd1;
                        r = make_result(EV_GOOD, b, kind);
                    end
                    owed_results.push_back(r);
                    parse_phase = PH_HUNT;
                end
                default: begin
                    if (b == DELIM) begin
                        parse_phase = PH_LENHI;
                        frame_type  = '0;
                        src_addr    = '0;
                        tx_status   = '0;
                    end else begin
                        // Stray byte: report with a blank frame context
                        parse_phase       = PH_HUNT;
                        r                 = make_result(EV_STRAY, b, KIND_OTHER);
                        r.sender_address  = '0;
                        r.delivery_status = '0;
                        r.payload_count   = '0;
                        owed_results.push_back(r);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Match one accepted result beat against the oldest owed result
        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("event_res", ADDR_W'(want.event_res), ADDR_W'(got.event_res));
            compare_field("data_byte", ADDR_W'(want.data_byte), ADDR_W'(got.data_byte));
            compare_field("frame_kind", ADDR_W'(want.frame_kind), ADDR_W'(got.frame_kind));
            compare_field("sender_address", want.sender_address, got.sender_address);
            compare_field("delivery_status", ADDR_W'(want.delivery_status),
                          ADDR_W'(got.delivery_status));
            compare_field("frame_counter", ADDR_W'(want.frame_counter),
                          ADDR_W'(got.frame_counter));
            compare_field("payload_count", ADDR_W'(want.payload_count),
                          ADDR_W'(got.payload_count));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    rafr_in_if  byte_if();
    rafr_out_if res_if();

    frame_event_checker checker_h = new();

    int unsigned burst_left;
    int unsigned bytes_sent;
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned quiet_cycles;

    radio_api_frame_receiver_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offer one byte, after a random gap when the current burst is used up
    task automatic send_byte(input t_octet b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap != 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        byte_if.valid   <= 1'b1;
        byte_if.byte_in <= b;
        do @(posedge i_clk); while (!(byte_if.valid && byte_if.ready));
        checker_h.take_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    function automatic t_octet noise_byte();
        t_octet b;
        do b = t_octet'($urandom_range(0, 255)); while (b == DELIM);
        return b;
    endfunction

    // Delimiter, big-endian length, body, then a checksum that is good unless corrupted
    task automatic send_frame(input t_octet body[$], input bit corrupt);
        t_octet           sum;
        logic [LEN_W-1:0] len;
        sum = '0;
        len = LEN_W'(body.size());
        send_byte(DELIM);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        foreach (body[i]) begin
            send_byte(body[i]);
            sum = sum + body[i];
        end
        sum = SUM_GOOD - sum;
        if (corrupt) sum = sum ^ t_octet'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // Mostly well-formed frames with random content, some noise and trailing junk
    task automatic random_frame();
        t_octet      body[$];
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 5)) send_byte(noise_byte());
        end else begin
            if (pick < 50)
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 13) : $urandom_range(12, 40);
            else if (pick < 78)
                len = $urandom_range(0, 12);
            else
                len = $urandom_range(0, 24);
            repeat (len) body.push_back(t_octet'($urandom_range(0, 255)));
            if (len > 0)
                body[0] = (pick < 50) ? TYPE_RX :
                          (pick < 78) ? TYPE_STATUS : t_octet'($urandom_range(0, 255));
            if (pick >= 50 && pick < 78 && len > STATUS_POS && $urandom_range(0, 1) == 1)
                body[STATUS_POS] = '0;
            send_frame(body, $urandom_range(0, 6) == 0);
            if (pick >= 95) repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        end
    endtask

    // Stop offering and let every owed result come out before touching the register
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        burst_left = 0;
        while (checker_h.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min_len(input logic [LEN_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        checker_h.set_min_rx_len(value);
    endtask

    // Result side: stall pattern that changes mode, plus requested long hold-offs
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        logic        rdy;
        res_if.ready = 1'b0;
        hold_served  = 0;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        tick         = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = ($urandom_range(0, 2) == 0);
                    default: rdy = ((tick % 5) != 0);
                endcase
            end
            res_if.ready <= rdy;
        end
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.event_res       = res_if.event_res;
            got.data_byte       = res_if.data_byte;
            got.frame_kind      = res_if.frame_kind;
            got.sender_address  = res_if.sender_address;
            got.delivery_status = res_if.delivery_status;
            got.frame_counter   = res_if.frame_counter;
            got.payload_count   = res_if.payload_count;
            checker_h.check_result(got);
        end
    end

    // Abort when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_octet      body[$];
        int unsigned target;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        byte_if.valid   = 1'b0;
        byte_if.byte_in = '0;
        burst_left      = 0;
        bytes_sent      = 0;
        hold_requests   = 0;
        quiet_cycles    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stray extremes, zero length, short and full status frames,
        // receive frames at and below the minimum, delimiter in payload, bad checksum
        send_byte(8'h00);
        send_byte(8'hFF);
        body = {};
        send_frame(body, 1'b0);
        body = {TYPE_STATUS, 8'h01};
        send_frame(body, 1'b0);
        body = {TYPE_STATUS, 8'h01, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00};
        send_frame(body, 1'b0);
        body = {TYPE_STATUS, 8'h02, 8'h12, 8'h34, 8'h00, 8'h24, 8'h00};
        send_frame(body, 1'b0);
        body = {TYPE_RX, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80,
                8'hFF, 8'hFE, 8'h01};
        send_frame(body, 1'b0);
        body = {TYPE_RX, 8'h00, 8'h13, 8'hA2, 8'h00, 8'h40, 8'h0A, 8'h01, 8'h27,
                8'hFF, 8'hFE, 8'h01, DELIM, 8'hFF};
        send_frame(body, 1'b1);
        body = {TYPE_RX, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
                8'h00, 8'h00};
        send_frame(body, 1'b0);
        body = {8'h88, DELIM};
        send_frame(body, 1'b0);

        target = bytes_sent + 220;
        while (bytes_sent < target) random_frame();

        // No minimum on receive frames; hold the result side off early on
        drain_results();
        write_min_len(16'h0000);
        hold_requests++;
        target = bytes_sent + 220;
        while (bytes_sent < target) random_frame();

        // Largest minimum, with one long receive frame that streams its payload
        drain_results();
        write_min_len(16'hFFFF);
        body = {TYPE_RX};
        repeat (40) body.push_back(t_octet'($urandom_range(0, 255)));
        send_frame(body, 1'b0);
        target = bytes_sent + 170;
        while (bytes_sent < target) random_frame();

        drain_results();
        write_min_len(16'd20);
        hold_requests++;
        target = bytes_sent + 170;
        while (bytes_sent < target) random_frame();

        // Run a string of good status frames to advance the frame counter
        drain_results();
        write_min_len(16'($urandom_range(6, 40)));
        repeat (24) begin
            body = {};
            repeat ($urandom_range(6, 8)) body.push_back(t_octet'($urandom_range(0, 255)));
            body[0]         = TYPE_STATUS;
            body[STATUS_POS] = '0;
            send_frame(body, 1'b0);
            if ($urandom_range(0, 7) == 0) random_frame();
        end
        target = bytes_sent + 80;
        while (bytes_sent < target) random_frame();

        drain_results();
        if (checker_h.failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rafr_pkg.sv
rtl/rafr_ifs.sv
rtl/radio_api_frame_receiver_top.sv
sim/testbench.sv
